@@ hdl/frc_pkg.sv @@
// Shared types, constants and a helper function for the fraction radix converter.
`timescale 1ns / 1ps

package frc_pkg;

  localparam int unsigned MaxDecimalDigits = 9;
  localparam int unsigned MaxBinaryBits    = 27;

  localparam int unsigned NumW   = 30;  // numerator and result width
  localparam int unsigned DigW   = 4;   // decimal_digits register width
  localparam int unsigned BitW   = 5;   // binary_bits register width
  localparam int unsigned CntW   = 5;   // step counter width
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 5;

  localparam logic [CfgIdxW-1:0] CFG_DECIMAL_DIGITS = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_BINARY_BITS    = 2'd1;

  localparam logic ACT_DEC_TO_BIN = 1'b0;
  localparam logic ACT_BIN_TO_DEC = 1'b1;

  localparam logic [DigW-1:0] DecimalDigitsReset = 4'd7;
  localparam logic [BitW-1:0] BinaryBitsReset    = 5'd16;

  typedef enum logic {
    S_IDLE,
    S_RUN
  } frc_state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } frc_cmd_t;

  typedef struct packed {
    logic done;
  } frc_sts_t;

  // Ten to the power n, for n in 1..9.
  function automatic logic [NumW-1:0] pow_ten(input logic [DigW-1:0] n);
    logic [NumW-1:0] p;
    case (n)
      4'd1:    p = 30'd10;
      4'd2:    p = 30'd100;
      4'd3:    p = 30'd1000;
      4'd4:    p = 30'd10000;
      4'd5:    p = 30'd100000;
      4'd6:    p = 30'd1000000;
      4'd7:    p = 30'd10000000;
      4'd8:    p = 30'd100000000;
      4'd9:    p = 30'd1000000000;
      default: p = 30'd1;
    endcase
    return p;
  endfunction

endpackage

@@ hdl/frc_if.sv @@
// Channel interfaces: request items, result items and configuration writes.
`timescale 1ns / 1ps

interface frc_req_if;
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic [frc_pkg::NumW-1:0]     numerator;
  modport source (output valid, output action, output numerator, input ready);
  modport sink   (input valid, input action, input numerator, output ready);
endinterface

interface frc_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [frc_pkg::NumW-1:0]     converted;
  logic                         out_of_range;
  modport source (output valid, output converted, output out_of_range, input ready);
  modport sink   (input valid, input converted, input out_of_range, output ready);
endinterface

interface frc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [frc_pkg::CfgIdxW-1:0]   index;
  logic [frc_pkg::CfgDatW-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/frc_ctrl.sv @@
// Controller: sequences load, conversion steps and hand-off to the result register.
`timescale 1ns / 1ps

module frc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output frc_pkg::frc_cmd_t cmd,
  input  frc_pkg::frc_sts_t sts
);

  frc_pkg::frc_state_t state, state_next;
  logic out_full, out_full_next;
  logic slot_free;

  assign slot_free = !out_full || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= frc_pkg::S_IDLE;
      out_full <= 1'b0;
    end else begin
      state    <= state_next;
      out_full <= out_full_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      frc_pkg::S_IDLE: begin
        if (req_valid) state_next = frc_pkg::S_RUN;
      end
      frc_pkg::S_RUN: begin
        if (sts.done && slot_free) state_next = frc_pkg::S_IDLE;
      end
      default: state_next = frc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    req_ready  = 1'b0;
    cmd.load   = 1'b0;
    cmd.step   = 1'b0;
    cmd.commit = 1'b0;
    case (state)
      frc_pkg::S_IDLE: begin
        req_ready = 1'b1;
        cmd.load  = req_valid;
      end
      frc_pkg::S_RUN: begin
        cmd.step   = !sts.done;
        cmd.commit = sts.done && slot_free;
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

  // The result register stays full until taken, unless a new result lands in it.
  assign out_full_next = cmd.commit || (out_full && !rsp_ready);
  assign rsp_valid     = out_full;

endmodule

@@ hdl/frc_dp.sv @@
// Datapath: configuration registers, working numerator, accumulator and result register.
`timescale 1ns / 1ps

module frc_dp (
  input  logic                      clk,
  input  logic                      rst,
  frc_cfg_if.sink                   cfg,
  input  logic                      action,
  input  logic [frc_pkg::NumW-1:0]  numerator,
  output logic [frc_pkg::NumW-1:0]  converted,
  output logic                      out_of_range,
  input  frc_pkg::frc_cmd_t         cmd,
  output frc_pkg::frc_sts_t         sts
);

  logic [frc_pkg::DigW-1:0] decimal_digits;
  logic [frc_pkg::BitW-1:0] binary_bits;
  logic [frc_pkg::DigW-1:0] nd;
  logic [frc_pkg::BitW-1:0] nb;

  logic                     mode;
  logic [frc_pkg::NumW-1:0] num;
  logic [frc_pkg::NumW-1:0] denom;
  logic [frc_pkg::NumW-1:0] acc;
  logic [frc_pkg::CntW-1:0] count;
  logic                     flag;
  logic [frc_pkg::NumW-1:0] conv_q;
  logic                     oor_q;

  logic [frc_pkg::NumW-1:0] load_denom;
  logic                     load_oor;
  logic [frc_pkg::BitW-1:0] align_sh;
  logic [26:0]              load_aligned;

  logic [frc_pkg::NumW:0]   dbl;
  logic                     ge;
  logic [frc_pkg::NumW:0]   times_ten;
  logic [3:0]               digit;
  logic [frc_pkg::NumW-1:0] acc_ten;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      decimal_digits <= frc_pkg::DecimalDigitsReset;
      binary_bits    <= frc_pkg::BinaryBitsReset;
    end else if (cfg.valid) begin
      if (cfg.index == frc_pkg::CFG_DECIMAL_DIGITS) begin
        decimal_digits <= cfg.data[frc_pkg::DigW-1:0];
      end else if (cfg.index == frc_pkg::CFG_BINARY_BITS) begin
        binary_bits <= cfg.data;
      end
    end
  end

  // Register values outside their range saturate into the legal range.
  always_comb begin
    if (decimal_digits == '0) begin
      nd = 4'd1;
    end else if (decimal_digits > 4'(frc_pkg::MaxDecimalDigits)) begin
      nd = 4'(frc_pkg::MaxDecimalDigits);
    end else begin
      nd = decimal_digits;
    end
    if (binary_bits == '0) begin
      nb = 5'd1;
    end else if (binary_bits > 5'(frc_pkg::MaxBinaryBits)) begin
      nb = 5'(frc_pkg::MaxBinaryBits);
    end else begin
      nb = binary_bits;
    end
  end

  // Binary input is left-aligned to 27 bits so each digit falls out of the top.
  assign align_sh     = 5'(frc_pkg::MaxBinaryBits) - nb;
  assign load_aligned = numerator[26:0] << align_sh;
  assign load_denom   = frc_pkg::pow_ten(nd);

  always_comb begin
    if (action == frc_pkg::ACT_DEC_TO_BIN) begin
      load_oor = numerator >= load_denom;
    end else begin
      load_oor = {1'b0, numerator} >= ((frc_pkg::NumW+1)'(1) << nb);
    end
  end

  assign dbl       = {num, 1'b0};
  assign ge        = dbl >= {1'b0, denom};
  assign times_ten = {num, 1'b0} + {num[frc_pkg::NumW-3:0], 3'b000};
  assign digit     = times_ten[30:27];
  assign acc_ten   = {acc[frc_pkg::NumW-2:0], 1'b0} + {acc[frc_pkg::NumW-4:0], 3'b000};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.load) begin
      if (load_oor) begin
        count <= '0;
      end else if (action == frc_pkg::ACT_DEC_TO_BIN) begin
        count <= nb;
      end else begin
        count <= {1'b0, nd};
      end
    end else if (cmd.step) begin
      count <= count - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode  <= action;
      denom <= load_denom;
      acc   <= '0;
      flag  <= load_oor;
      if (action == frc_pkg::ACT_DEC_TO_BIN) begin
        num <= numerator;
      end else begin
        num <= {3'b000, load_aligned};
      end
    end else if (cmd.step) begin
      if (mode == frc_pkg::ACT_DEC_TO_BIN) begin
        num <= ge ? frc_pkg::NumW'(dbl - {1'b0, denom}) : dbl[frc_pkg::NumW-1:0];
        acc <= {acc[frc_pkg::NumW-2:0], ge};
      end else begin
        num <= {3'b000, times_ten[26:0]};
        acc <= acc_ten + {26'd0, digit};
      end
    end
    if (cmd.commit) begin
      conv_q <= acc;
      oor_q  <= flag;
    end
  end

  assign sts.done     = count == '0;
  assign converted    = conv_q;
  assign out_of_range = oor_q;

endmodule

@@ hdl/fraction_radix_converter_core.sv @@
// Top level of the fraction radix converter: controller, datapath and checks.
`timescale 1ns / 1ps

// Converts a fixed-point fraction between decimal and binary, one item at a time.
// Action 0 reads numerator over 10^decimal_digits and yields binary_bits bits by
// repeated doubling and compare-subtract; action 1 reads numerator over
// 2^binary_bits and yields decimal_digits digits by repeated multiply-by-ten.
// Both truncate. The steps run in S_RUN; the result is then committed to the
// result register once that register is free, and rsp.valid rises with it. An
// out-of-range numerator skips the steps and returns zero with out_of_range set.
// The controller returns to S_IDLE with the commit and takes the next item only
// then, so one item is in work at a time. The one shared step unit in the
// datapath makes one bit or digit per cycle. A finished result waits in its own
// register, so the next item is accepted while it is still pending. Register
// values outside their range saturate to the nearest legal count.
module fraction_radix_converter_core (
  input  logic      clk,
  input  logic      rst,
  frc_req_if.sink   req,
  frc_rsp_if.source rsp,
  frc_cfg_if.sink   cfg
);

  frc_pkg::frc_cmd_t cmd;
  frc_pkg::frc_sts_t sts;

  frc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  frc_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .action       (req.action),
    .numerator    (req.numerator),
    .converted    (rsp.converted),
    .out_of_range (rsp.out_of_range),
    .cmd          (cmd),
    .sts          (sts)
  );

  // A flagged item carries a zero result.
  assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.out_of_range |-> rsp.converted == '0)
    else $error("out_of_range item with nonzero result");

  // Only one item is in work at a time.
  assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request taken while an item is in work");

  // Results never exceed nine decimal digits.
  assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.converted <= 30'd999999999)
    else $error("result exceeds nine decimal digits");

endmodule
